// File: hw/rtl/clsl_pkg.sv
// Shared types, token codes, character codes and keyword table for the source lexer.
package clsl_pkg;

    localparam int CH_W     = 8;
    localparam int KIND_W   = 6;
    localparam int LEN_W    = 8;
    localparam int START_W  = 32;
    localparam int KW_NUM   = 11;
    localparam int KW_CHARS = 8;
    localparam int KW_LEN_W = 4;

    // Input item: op selects character or end of input.
    typedef struct packed {
        logic            op;
        logic [CH_W-1:0] ch;
    } in_item_t;

    // Result item: one token.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   length;
        logic               last;
    } out_item_t;

    // Up to two tokens handed from the lexer core to the result queue.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  tok0;
        out_item_t  tok1;
    } tok_push_t;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_END      = 6'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT     = 6'd1;
    localparam logic [KIND_W-1:0] KIND_INT      = 6'd2;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 6'd13;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 6'd14;
    localparam logic [KIND_W-1:0] KIND_STAR     = 6'd15;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 6'd16;
    localparam logic [KIND_W-1:0] KIND_PERCENT  = 6'd17;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 6'd18;
    localparam logic [KIND_W-1:0] KIND_EQ       = 6'd19;
    localparam logic [KIND_W-1:0] KIND_NE       = 6'd20;
    localparam logic [KIND_W-1:0] KIND_LT       = 6'd21;
    localparam logic [KIND_W-1:0] KIND_GT       = 6'd22;
    localparam logic [KIND_W-1:0] KIND_LE       = 6'd23;
    localparam logic [KIND_W-1:0] KIND_GE       = 6'd24;
    localparam logic [KIND_W-1:0] KIND_LAND     = 6'd25;
    localparam logic [KIND_W-1:0] KIND_LOR      = 6'd26;
    localparam logic [KIND_W-1:0] KIND_AMP      = 6'd27;
    localparam logic [KIND_W-1:0] KIND_BAR      = 6'd28;
    localparam logic [KIND_W-1:0] KIND_INC      = 6'd29;
    localparam logic [KIND_W-1:0] KIND_DEC      = 6'd30;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 6'd31;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 6'd32;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 6'd33;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 6'd34;
    localparam logic [KIND_W-1:0] KIND_LBRACK   = 6'd35;
    localparam logic [KIND_W-1:0] KIND_RBRACK   = 6'd36;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 6'd37;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 6'd38;

    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CH_W-1:0] CH_EQ      = 8'h3D;
    localparam logic [CH_W-1:0] CH_LT      = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT      = 8'h3E;
    localparam logic [CH_W-1:0] CH_AMP     = 8'h26;
    localparam logic [CH_W-1:0] CH_BAR     = 8'h7C;
    localparam logic [CH_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [CH_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CH_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [CH_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CH_W-1:0] CH_BANG    = 8'h21;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT      = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF      = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;

    // Keyword spellings, first character in the low byte, zero padded.
    // Entry k gives token kind KIND_INT + k.
    localparam logic [KW_NUM-1:0][KW_CHARS*CH_W-1:0] KW_TEXT = {
        64'h0000006B61657262,   // break
        64'h65756E69746E6F63,   // continue
        64'h0000000000006F64,   // do
        64'h000000656C696877,   // while
        64'h0000000000726F66,   // for
        64'h0000000065736C65,   // else
        64'h0000000000006669,   // if
        64'h0000000064696F76,   // void
        64'h0000000072616863,   // char
        64'h0000656C62756F64,   // double
        64'h0000000000746E69    // int
    };

    localparam logic [KW_NUM-1:0][KW_LEN_W-1:0] KW_LEN = {
        4'd5, 4'd8, 4'd2, 4'd5, 4'd3, 4'd4, 4'd2, 4'd4, 4'd4, 4'd6, 4'd3
    };

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    // Token of a stop character alone; KIND_END for any other byte.
    function automatic logic [KIND_W-1:0] single_kind(input logic [CH_W-1:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_SLASH:   k = KIND_SLASH;
            CH_PERCENT: k = KIND_PERCENT;
            CH_EQ:      k = KIND_ASSIGN;
            CH_LT:      k = KIND_LT;
            CH_GT:      k = KIND_GT;
            CH_AMP:     k = KIND_AMP;
            CH_BAR:     k = KIND_BAR;
            CH_LBRACE:  k = KIND_LBRACE;
            CH_RBRACE:  k = KIND_RBRACE;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_LBRACK:  k = KIND_LBRACK;
            CH_RBRACK:  k = KIND_RBRACK;
            CH_SEMI:    k = KIND_SEMI;
            CH_BANG:    k = KIND_ERROR;
            default:    k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic logic can_pair(input logic [CH_W-1:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_AMP) || (c == CH_BAR);
    endfunction

    // Joined two-character operator; KIND_END when the pair does not join.
    function automatic logic [KIND_W-1:0] pair_kind(input logic [CH_W-1:0] p,
                                                    input logic [CH_W-1:0] c);
        logic [KIND_W-1:0] k;
        k = KIND_END;
        priority if (c == CH_EQ && p == CH_EQ)   k = KIND_EQ;
        else if (c == CH_EQ && p == CH_BANG)     k = KIND_NE;
        else if (c == CH_EQ && p == CH_LT)       k = KIND_LE;
        else if (c == CH_EQ && p == CH_GT)       k = KIND_GE;
        else if (c == p && p == CH_AMP)          k = KIND_LAND;
        else if (c == p && p == CH_BAR)          k = KIND_LOR;
        else if (c == p && p == CH_PLUS)         k = KIND_INC;
        else if (c == p && p == CH_MINUS)        k = KIND_DEC;
        else                                     k = KIND_END;
        return k;
    endfunction

endpackage

// File: hw/rtl/c_like_source_lexer.sv
// An item is registered in the core input register; its tokens are written into the token queue and read on m_.
// Throughput: one item per cycle while the four-entry token queue has two free entries; the
//   single result port drains the queue one token at a time, so two-token items can stall the input.
// Reset (aresetn low, synchronous): position, word, pending operator and queue clear;
//   the keyword character buffer is not reset and is only read once written.
module c_like_source_lexer #(
    parameter int POS_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  clsl_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output clsl_pkg::out_item_t m_item
);

    // Core to queue: token bundle and back-pressure.
    clsl_pkg::tok_push_t push;
    logic                space_ok;

    // Core holds the input item register plus the lexer state (word length and
    // start, first eight word bytes for keyword compare, pending operator, byte
    // position). One registered item is resolved per cycle into zero, one or two
    // tokens; the core stalls while the queue has fewer than two free entries.
    clsl_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .space_ok (space_ok),
        .push     (push)
    );

    // Queue decouples the two sides so new items keep coming in while a token
    // waits on m_ready, and serializes two-token items onto the single port.
    clsl_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// File: hw/rtl/clsl_kw_match.sv
// Parallel keyword compare of the buffered word against the keyword table.
module clsl_kw_match (
    input  logic [clsl_pkg::KW_CHARS-1:0][clsl_pkg::CH_W-1:0] word_chars,
    input  logic [clsl_pkg::LEN_W-1:0]                        word_len,
    output logic [clsl_pkg::KIND_W-1:0]                       kind
);

    logic [clsl_pkg::KW_NUM-1:0] hit;

    // Only characters below the word length are compared; the rest may be stale.
    always_comb begin
        kind = clsl_pkg::KIND_TEXT;
        for (int k = 0; k < clsl_pkg::KW_NUM; k++) begin
            hit[k] = (word_len == clsl_pkg::LEN_W'(clsl_pkg::KW_LEN[k]));
            for (int i = 0; i < clsl_pkg::KW_CHARS; i++) begin
                if (clsl_pkg::KW_LEN_W'(i) < clsl_pkg::KW_LEN[k] &&
                    word_chars[i] != clsl_pkg::KW_TEXT[k][clsl_pkg::CH_W*i +: clsl_pkg::CH_W]) begin
                    hit[k] = 1'b0;
                end
            end
        end
        for (int k = 0; k < clsl_pkg::KW_NUM; k++) begin
            if (hit[k]) begin
                kind = clsl_pkg::KIND_W'(clsl_pkg::KIND_INT + clsl_pkg::KIND_W'(k));
            end
        end
    end

endmodule

// File: hw/rtl/clsl_core.sv
// Lexer core: input register, word and operator state, token build for one item.
module clsl_core #(
    parameter int POS_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  clsl_pkg::in_item_t  s_item,
    input  logic                space_ok,
    output clsl_pkg::tok_push_t push
);

    localparam int IDX_W = $clog2(clsl_pkg::KW_CHARS);

    logic                                              in_valid_reg, in_valid_next;
    clsl_pkg::in_item_t                                in_item_reg;
    logic [clsl_pkg::LEN_W-1:0]                        word_len_reg, word_len_next;
    logic [POS_BITS-1:0]                               word_start_reg, word_start_next;
    logic [POS_BITS-1:0]                               pos_reg, pos_next;
    logic [clsl_pkg::CH_W-1:0]                         pend_op_reg, pend_op_next;
    logic                                              pend_valid_reg, pend_valid_next;
    logic [clsl_pkg::KW_CHARS-1:0][clsl_pkg::CH_W-1:0] word_chars_reg;

    logic                         fire;
    logic                         chars_we;
    logic                         word_open;
    logic [POS_BITS-1:0]          pos_prev;
    logic [clsl_pkg::KIND_W-1:0]  kw_kind;
    logic [clsl_pkg::KIND_W-1:0]  ch_kind;
    logic [clsl_pkg::KIND_W-1:0]  pk;
    logic                         joined;
    clsl_pkg::out_item_t          flush_tok;
    logic                         flush_v;
    clsl_pkg::out_item_t          first_tok, second_tok;
    logic                         first_v, second_v;

    function automatic clsl_pkg::out_item_t make_tok(
        input logic [clsl_pkg::KIND_W-1:0]  kind,
        input logic [clsl_pkg::START_W-1:0] start,
        input logic [clsl_pkg::LEN_W-1:0]   len
    );
        clsl_pkg::out_item_t t;
        t.kind      = kind;
        t.start_res = start;
        t.length    = len;
        t.last      = 1'b0;
        return t;
    endfunction

    clsl_kw_match u_kw_match (
        .word_chars (word_chars_reg),
        .word_len   (word_len_reg),
        .kind       (kw_kind)
    );

    assign fire    = in_valid_reg && space_ok;
    assign s_ready = !in_valid_reg || space_ok;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    assign word_open = (word_len_reg != '0);
    assign pos_prev  = pos_reg - POS_BITS'(1);
    assign ch_kind   = clsl_pkg::single_kind(in_item_reg.ch);
    assign pk        = clsl_pkg::pair_kind(pend_op_reg, in_item_reg.ch);
    assign joined    = pend_valid_reg && (pk != clsl_pkg::KIND_END);
    assign flush_v   = word_open || pend_valid_reg;

    // A word and a pending operator are never open together.
    assign flush_tok = word_open
        ? make_tok(kw_kind, clsl_pkg::START_W'(word_start_reg), word_len_reg)
        : make_tok(clsl_pkg::single_kind(pend_op_reg), clsl_pkg::START_W'(pos_prev),
                   clsl_pkg::LEN_W'(1));

    always_comb begin
        first_v         = 1'b0;
        first_tok       = flush_tok;
        second_v        = 1'b0;
        second_tok      = make_tok(ch_kind, clsl_pkg::START_W'(pos_reg), clsl_pkg::LEN_W'(1));
        word_len_next   = word_len_reg;
        word_start_next = word_start_reg;
        pos_next        = pos_reg;
        pend_op_next    = pend_op_reg;
        pend_valid_next = pend_valid_reg;
        chars_we        = 1'b0;

        if (in_item_reg.op == clsl_pkg::OP_END) begin
            first_v         = flush_v;
            second_v        = 1'b1;
            second_tok      = make_tok(clsl_pkg::KIND_END, clsl_pkg::START_W'(pos_reg), '0);
            word_len_next   = '0;
            pend_valid_next = 1'b0;
        end else begin
            pos_next = pos_reg + POS_BITS'(1);
            if (clsl_pkg::is_space(in_item_reg.ch)) begin
                first_v         = flush_v;
                word_len_next   = '0;
                pend_valid_next = 1'b0;
            end else if (ch_kind != clsl_pkg::KIND_END) begin
                word_len_next = '0;
                if (joined) begin
                    first_v         = 1'b1;
                    first_tok       = make_tok(pk, clsl_pkg::START_W'(pos_prev),
                                               clsl_pkg::LEN_W'(2));
                    pend_valid_next = 1'b0;
                end else begin
                    first_v = flush_v;
                    if (clsl_pkg::can_pair(in_item_reg.ch)) begin
                        pend_valid_next = 1'b1;
                        pend_op_next    = in_item_reg.ch;
                    end else begin
                        second_v        = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
            end else begin
                // word byte: a pending operator goes out alone first
                first_v         = pend_valid_reg;
                pend_valid_next = 1'b0;
                if (!word_open) begin
                    word_start_next = pos_reg;
                end
                chars_we = (word_len_reg < clsl_pkg::LEN_W'(clsl_pkg::KW_CHARS));
                if (word_len_reg != '1) begin
                    word_len_next = word_len_reg + clsl_pkg::LEN_W'(1);
                end
            end
        end
    end

    always_comb begin
        push.tok0      = first_v ? first_tok : second_tok;
        push.tok0.last = !(first_v && second_v);
        push.tok1      = second_tok;
        push.tok1.last = 1'b1;
        push.count     = fire ? (2'(first_v) + 2'(second_v)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            word_len_reg   <= '0;
            word_start_reg <= '0;
            pos_reg        <= '0;
            pend_op_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                word_len_reg   <= word_len_next;
                word_start_reg <= word_start_next;
                pos_reg        <= pos_next;
                pend_op_reg    <= pend_op_next;
                pend_valid_reg <= pend_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (fire && chars_we) begin
            word_chars_reg[word_len_reg[IDX_W-1:0]] <= in_item_reg.ch;
        end
    end

endmodule

// File: hw/rtl/clsl_outq.sv
// Four-entry result queue: takes up to two tokens a cycle while space_ok, sends one a cycle while m_ready.
module clsl_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  clsl_pkg::tok_push_t push,
    output logic                space_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output clsl_pkg::out_item_t m_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    clsl_pkg::out_item_t  entries_reg [DEPTH];
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;

    assign m_valid  = (count_reg != '0);
    assign m_item   = entries_reg[head_reg];
    assign pop      = m_valid && m_ready;
    assign space_ok = (count_reg <= CNT_W'(DEPTH - 2));

    assign head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
    assign tail_next  = tail_reg + PTR_W'(push.count);
    assign count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[tail_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            entries_reg[tail_reg + PTR_W'(1)] <= push.tok1;
        end
    end

endmodule

// File: sim/lexer_checker.sv
// Token checker for the source lexer: predicts tokens from accepted items and compares results.
module lexer_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  clsl_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  clsl_pkg::out_item_t m_item,
    output int                  error_count,
    output int                  tokens_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import clsl_pkg::*;

    localparam int BUF_DEPTH  = 8;
    localparam int LEN_MAX    = 255;

    // Lexer state as predicted
    logic [CH_W-1:0]    word_buf [BUF_DEPTH];
    int unsigned        word_len;
    logic [START_W-1:0] word_start;
    logic [START_W-1:0] cursor;
    logic [CH_W-1:0]    held_op;
    logic               held_valid;

    out_item_t token_fifo[$];
    out_item_t new_tokens[$];
    int        errors = 0;
    int        owed = 0;

    assign error_count = errors;
    assign tokens_owed = owed;

    function automatic logic blank_char(input logic [CH_W-1:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // KIND_END means the byte is not a stop character
    function automatic logic [KIND_W-1:0] stop_token(input logic [CH_W-1:0] c);
        case (c)
            CH_PLUS:    return KIND_PLUS;
            CH_MINUS:   return KIND_MINUS;
            CH_STAR:    return KIND_STAR;
            CH_SLASH:   return KIND_SLASH;
            CH_PERCENT: return KIND_PERCENT;
            CH_EQ:      return KIND_ASSIGN;
            CH_LT:      return KIND_LT;
            CH_GT:      return KIND_GT;
            CH_AMP:     return KIND_AMP;
            CH_BAR:     return KIND_BAR;
            CH_LBRACE:  return KIND_LBRACE;
            CH_RBRACE:  return KIND_RBRACE;
            CH_LPAREN:  return KIND_LPAREN;
            CH_RPAREN:  return KIND_RPAREN;
            CH_LBRACK:  return KIND_LBRACK;
            CH_RBRACK:  return KIND_RBRACK;
            CH_SEMI:    return KIND_SEMI;
            CH_BANG:    return KIND_ERROR;
            default:    return KIND_END;
        endcase
    endfunction

    function automatic logic may_join(input logic [CH_W-1:0] c);
        case (c)
            CH_EQ, CH_BANG, CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_AMP, CH_BAR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] joined_token(input logic [CH_W-1:0] p,
                                                       input logic [CH_W-1:0] c);
        if (c == CH_EQ) begin
            case (p)
                CH_EQ:   return KIND_EQ;
                CH_BANG: return KIND_NE;
                CH_LT:   return KIND_LE;
                CH_GT:   return KIND_GE;
                default: return KIND_END;
            endcase
        end else if (c == p) begin
            case (p)
                CH_AMP:   return KIND_LAND;
                CH_BAR:   return KIND_LOR;
                CH_PLUS:  return KIND_INC;
                CH_MINUS: return KIND_DEC;
                default:  return KIND_END;
            endcase
        end
        return KIND_END;
    endfunction

    // Keyword k maps to kind KIND_INT + k
    function automatic string keyword_spelling(input int k);
        case (k)
            0:       return "int";
            1:       return "double";
            2:       return "char";
            3:       return "void";
            4:       return "if";
            5:       return "else";
            6:       return "for";
            7:       return "while";
            8:       return "do";
            9:       return "continue";
            default: return "break";
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] word_token();
        string spelling;
        logic  same;
        if (word_len > BUF_DEPTH)
            return KIND_TEXT;
        for (int k = 0; k < KW_NUM; k++) begin
            spelling = keyword_spelling(k);
            same = (spelling.len() == word_len);
            for (int i = 0; same && i < spelling.len(); i++)
                if (spelling[i] != word_buf[i])
                    same = 1'b0;
            if (same)
                return KIND_INT + KIND_W'(k);
        end
        return KIND_TEXT;
    endfunction

    function automatic void emit(input logic [KIND_W-1:0] kind,
                                 input logic [START_W-1:0] start,
                                 input int unsigned len);
        out_item_t tok;
        tok.kind      = kind;
        tok.start_res = start;
        tok.length    = (len > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(len);
        tok.last      = 1'b0;
        new_tokens.push_back(tok);
    endfunction

    // Close the open word, then the held operator
    function automatic void flush_open();
        if (word_len > 0) begin
            emit(word_token(), word_start, word_len);
            word_len = 0;
        end
        if (held_valid) begin
            emit(stop_token(held_op), cursor - 1'b1, 1);
            held_valid = 1'b0;
            held_op    = '0;
        end
    endfunction

    function automatic void lex_item(input in_item_t it);
        logic [CH_W-1:0]   c;
        logic [KIND_W-1:0] pk;
        logic              joined;
        c = it.ch;
        new_tokens.delete();
        if (it.op == OP_END) begin
            flush_open();
            emit(KIND_END, cursor, 0);
        end else begin
            if (blank_char(c)) begin
                flush_open();
            end else if (stop_token(c) != KIND_END) begin
                joined = 1'b0;
                if (word_len > 0)
                    flush_open();
                if (held_valid) begin
                    pk = joined_token(held_op, c);
                    if (pk != KIND_END) begin
                        emit(pk, cursor - 1'b1, 2);
                        held_valid = 1'b0;
                        held_op    = '0;
                        joined     = 1'b1;
                    end else begin
                        flush_open();
                    end
                end
                if (!joined) begin
                    if (may_join(c)) begin
                        held_op    = c;
                        held_valid = 1'b1;
                    end else begin
                        emit(stop_token(c), cursor, 1);
                    end
                end
            end else begin
                if (held_valid)
                    flush_open();
                if (word_len == 0)
                    word_start = cursor;
                if (word_len < BUF_DEPTH)
                    word_buf[word_len] = c;
                if (word_len < LEN_MAX)
                    word_len++;
            end
            cursor = cursor + 1'b1;
        end
        if (new_tokens.size() > 0)
            new_tokens[new_tokens.size()-1].last = 1'b1;
        foreach (new_tokens[i])
            token_fifo.push_back(new_tokens[i]);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t ns: token mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin : token_watch
        out_item_t want;
        if (!aresetn) begin
            word_len   = 0;
            word_start = '0;
            cursor     = '0;
            held_op    = '0;
            held_valid = 1'b0;
            token_fifo.delete();
        end else begin
            if (s_valid && s_ready)
                lex_item(s_item);
            if (m_valid && m_ready) begin
                if (token_fifo.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                              m_item.kind, m_item.start_res));
                end else begin
                    want = token_fifo.pop_front();
                    if (m_item.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                                  m_item.kind, want.kind, want.start_res));
                    if (m_item.start_res !== want.start_res)
                        report_mismatch($sformatf("start %0d, want %0d (kind %0d)",
                                                  m_item.start_res, want.start_res,
                                                  want.kind));
                    if (m_item.length !== want.length)
                        report_mismatch($sformatf("length %0d, want %0d (start %0d)",
                                                  m_item.length, want.length,
                                                  want.start_res));
                    if (m_item.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b (start %0d)",
                                                  m_item.last, want.last, want.start_res));
                end
            end
        end
        owed = token_fifo.size();
    end

endmodule

// File: sim/tb_top.sv
// Bench top for the source lexer: clock, reset, item stimulus, result stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clsl_pkg::*;

    localparam int      HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the token queue
    localparam int      BULK_ITEMS      = 1650;  // random items with idling allowed
    localparam int      TOTAL_ITEMS     = 1950;  // then a stretch with no idling at all
    localparam int      MODE_SPAN       = 150;   // items between idling mode changes
    localparam int      TAIL_CYCLES     = 16;    // extra wait after the last owed token, to catch strays
    localparam longint  RUN_LIMIT       = 2_000_000;  // ns, far beyond the slowest clean run
    localparam int      KW_IDX_WHILE    = 7;

    localparam logic [CH_W-1:0] CH_A    = 8'h61;
    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_HIGH = 8'h80;

    // Every stop character, including the bang
    localparam logic [17:0][CH_W-1:0] STOP_CHARS = {
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_EQ, CH_LT, CH_GT, CH_AMP,
        CH_BAR, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
        CH_SEMI, CH_BANG
    };
    localparam logic [5:0][CH_W-1:0] BLANK_CHARS = {
        CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR
    };
    // Every two-character operator, first character in the upper byte
    localparam logic [7:0][2*CH_W-1:0] PAIR_CHARS = {
        {CH_EQ, CH_EQ}, {CH_BANG, CH_EQ}, {CH_LT, CH_EQ}, {CH_GT, CH_EQ},
        {CH_AMP, CH_AMP}, {CH_BAR, CH_BAR}, {CH_PLUS, CH_PLUS}, {CH_MINUS, CH_MINUS}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int        error_count;
    int        tokens_owed;

    // Shared knobs between the source and the result sink
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_off_req = 1'b0;
    int unsigned sent_items   = 0;

    c_like_source_lexer #(
        .POS_BITS(32)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    lexer_checker token_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .error_count (error_count),
        .tokens_owed (tokens_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the handshake locks up
    initial begin : watchdog
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one item from a falling edge and hold it until accepted. Valid stays high on
    // return, so a back-to-back item without an idle gap only rewrites the payload in the next falling edge.
    task automatic drive_item(input in_item_t it);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_items++;
    endtask

    task automatic send_char(input logic [CH_W-1:0] c);
        in_item_t it;
        it.op = OP_CHAR;
        it.ch = c;
        drive_item(it);
    endtask

    // End mark; the byte lane carries noise since the block ignores it
    task automatic send_end();
        in_item_t it;
        it.op = OP_END;
        it.ch = CH_W'($urandom_range(0, 255));
        drive_item(it);
    endtask

    task automatic send_keyword(input int k);
        for (int i = 0; i < KW_LEN[k]; i++)
            send_char(KW_TEXT[k][CH_W*i +: CH_W]);
    endtask

    // Letters, digits and high bytes: none are blank or stop characters
    function automatic logic [CH_W-1:0] word_byte();
        case ($urandom_range(0, 3))
            0, 1:    return CH_A + CH_W'($urandom_range(0, 25));
            2:       return CH_ZERO + CH_W'($urandom_range(0, 9));
            default: return CH_HIGH + CH_W'($urandom_range(0, 127));
        endcase
    endfunction

    // One piece of source text. Mostly well-formed tokens so that keywords, joined
    // operators and flushes get hit often; adjacency without a separator is left to
    // chance, which also produces run-on words and broken pairs.
    task automatic send_random_token();
        int                 pick;
        logic [2*CH_W-1:0]  pair;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            send_keyword($urandom_range(0, KW_NUM - 1));
        end else if (pick < 36) begin
            repeat ($urandom_range(1, 12)) send_char(word_byte());
        end else if (pick < 49) begin
            pair = PAIR_CHARS[$urandom_range(0, 7)];
            send_char(pair[2*CH_W-1:CH_W]);
            send_char(pair[CH_W-1:0]);
        end else if (pick < 62) begin
            send_char(STOP_CHARS[$urandom_range(0, 17)]);
        end else if (pick < 84) begin
            send_char(BLANK_CHARS[$urandom_range(0, 5)]);
        end else if (pick < 98) begin
            // raw noise: any byte, zero and 0xFF included
            send_char(CH_W'($urandom_range(0, 255)));
        end else begin
            send_end();
        end
    endtask

    // Result side: random short stalls, one long hold-off on request, or always ready.
    // Each pass starts on a falling edge and assigns m_ready exactly once.
    initial begin : result_sink
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned next_mode;
        bit          long_done;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extreme bytes as a word, lone bang, pairs that do not join,
        // two joined forms, a keyword cut off by an operator, end flushing a held
        // operator, a repeated end mark, and every kind of whitespace.
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_TAB);
        send_char(CH_BANG);
        send_char(CH_SEMI);
        send_char(CH_LT);
        send_char(CH_LT);
        send_char(CH_EQ);
        send_char(CH_BANG);
        send_char(CH_EQ);
        send_char(CH_AMP);
        send_keyword(KW_IDX_WHILE);
        send_char(CH_MINUS);
        send_end();
        send_end();
        send_char(CH_VT);
        send_char(CH_FF);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_SPACE);

        // Receiver holds off while the source streams without gaps: the token queue
        // fills and s_ready must drop until the stall ends.
        hold_off_req = 1'b1;
        src_idle_on  = 1'b0;
        repeat (60) send_random_token();
        src_idle_on  = 1'b1;

        // Random part, idling mode reshuffled now and then so that some stretches
        // run with no gaps on one or both sides
        next_mode = sent_items + MODE_SPAN;
        long_done = 1'b0;
        while (sent_items < BULK_ITEMS) begin
            if (sent_items >= next_mode) begin
                src_idle_on  = ($urandom_range(0, 2) != 0);
                sink_idle_on = ($urandom_range(0, 2) != 0);
                next_mode    = sent_items + MODE_SPAN;
            end
            if (!long_done && sent_items > BULK_ITEMS / 2) begin
                // one word long enough to saturate the length field
                send_char(CH_SPACE);
                repeat ($urandom_range(255, 260)) send_char(word_byte());
                send_char(CH_SPACE);
                long_done = 1'b1;
            end
            send_random_token();
        end

        // Last stretch at full rate on both sides
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (sent_items < TOTAL_ITEMS)
            send_random_token();
        send_end();
        s_valid <= 1'b0;

        while (tokens_owed != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/clsl_pkg.sv
hw/rtl/clsl_kw_match.sv
hw/rtl/clsl_core.sv
hw/rtl/clsl_outq.sv
hw/rtl/c_like_source_lexer.sv
sim/lexer_checker.sv
sim/tb_top.sv
